/* sv/note_to_gamma_rgb_color_unit_macros.svh */
// Assertion macros used by the checker of the colour unit
`ifndef NOTE_TO_GAMMA_RGB_COLOR_UNIT_MACROS_SVH
`define NOTE_TO_GAMMA_RGB_COLOR_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define NTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define NTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ntg_pkg.sv */
// Shared constants and tables of the note to gamma colour unit
package ntg_pkg;

    localparam int NOTE_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = 1'd1;

    localparam logic [15:0] SEG_MID_START = 16'd21845;
    localparam logic [15:0] SEG_TOP_START = 16'd43690;
    localparam logic [6:0]  SEG_LOW_SLOPE = 7'd43;
    localparam logic [6:0]  SEG_MID_SLOPE = 7'd85;
    localparam logic [6:0]  SEG_TOP_SLOPE = 7'd127;
    localparam logic [8:0]  SEG_LOW_BASE  = 9'd298;
    localparam logic [8:0]  SEG_MID_BASE  = 9'd255;
    localparam logic [8:0]  SEG_TOP_BASE  = 9'd170;

    localparam int HUE_SHIFT = 38;
    localparam longint unsigned HUE_RECIP_LM = ((64'd1 << HUE_SHIFT) + 64'd21844) / 64'd21845;
    localparam longint unsigned HUE_RECIP_T  = ((64'd1 << HUE_SHIFT) + 64'd21845) / 64'd21846;
    localparam logic [23:0] HUE_M_LM = 24'(HUE_RECIP_LM);
    localparam logic [23:0] HUE_M_T  = 24'(HUE_RECIP_T);

    localparam logic [1:0] SEG_LOW = 2'd0;
    localparam logic [1:0] SEG_MID = 2'd1;
    localparam logic [1:0] SEG_TOP = 2'd2;

    localparam logic [2:0] SEC_RG = 3'd0;
    localparam logic [2:0] SEC_GR = 3'd1;
    localparam logic [2:0] SEC_GB = 3'd2;
    localparam logic [2:0] SEC_BG = 3'd3;
    localparam logic [2:0] SEC_BR = 3'd4;
    localparam logic [2:0] SEC_RB = 3'd5;

    localparam logic [7:0] SEC_B1 = 8'd43;
    localparam logic [7:0] SEC_B2 = 8'd85;
    localparam logic [7:0] SEC_B3 = 8'd128;
    localparam logic [7:0] SEC_B4 = 8'd171;
    localparam logic [7:0] SEC_B5 = 8'd213;

    // ramp*255/43 as one multiply and shift
    localparam int          RAMP_SHIFT = 20;
    localparam logic [22:0] RAMP_M     = 23'd6218430;

    localparam logic [7:0] GAMMA_LUT [256] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
        8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4,
        8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6,
        8'd6, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd9,
        8'd9, 8'd9, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12,
        8'd12, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15,
        8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19,
        8'd20, 8'd20, 8'd21, 8'd22, 8'd22, 8'd23, 8'd23, 8'd24,
        8'd25, 8'd25, 8'd26, 8'd26, 8'd27, 8'd28, 8'd28, 8'd29,
        8'd30, 8'd30, 8'd31, 8'd32, 8'd33, 8'd33, 8'd34, 8'd35,
        8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd39, 8'd40, 8'd41,
        8'd42, 8'd43, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48,
        8'd49, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
        8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63,
        8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71,
        8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd81,
        8'd82, 8'd83, 8'd84, 8'd85, 8'd87, 8'd88, 8'd89, 8'd90,
        8'd91, 8'd93, 8'd94, 8'd95, 8'd97, 8'd98, 8'd99, 8'd100,
        8'd102, 8'd103, 8'd105, 8'd106, 8'd107, 8'd109, 8'd110, 8'd111,
        8'd113, 8'd114, 8'd116, 8'd117, 8'd119, 8'd120, 8'd121, 8'd123,
        8'd124, 8'd126, 8'd127, 8'd129, 8'd130, 8'd132, 8'd133, 8'd135,
        8'd137, 8'd138, 8'd140, 8'd141, 8'd143, 8'd145, 8'd146, 8'd148,
        8'd149, 8'd151, 8'd153, 8'd154, 8'd156, 8'd158, 8'd159, 8'd161,
        8'd163, 8'd165, 8'd166, 8'd168, 8'd170, 8'd172, 8'd173, 8'd175,
        8'd177, 8'd179, 8'd181, 8'd182, 8'd184, 8'd186, 8'd188, 8'd190,
        8'd192, 8'd194, 8'd196, 8'd197, 8'd199, 8'd201, 8'd203, 8'd205,
        8'd207, 8'd209, 8'd211, 8'd213, 8'd215, 8'd217, 8'd219, 8'd221,
        8'd223, 8'd225, 8'd227, 8'd229, 8'd231, 8'd234, 8'd236, 8'd238,
        8'd240, 8'd242, 8'd244, 8'd246, 8'd248, 8'd251, 8'd253, 8'd255
    };

endpackage

/* sv/ntg_if.sv */
// Item channels of the colour unit: note items in, colour items out
interface ntg_note_if;
    logic                          valid;
    logic                          ready;
    logic [ntg_pkg::NOTE_W-1:0]    note;
    logic [ntg_pkg::BYTE_W-1:0]    brightness;

    modport source (output valid, output note, output brightness, input ready);
    modport sink (input valid, input note, input brightness, output ready);
endinterface

interface ntg_color_if;
    logic                          valid;
    logic                          ready;
    logic [ntg_pkg::BYTE_W-1:0]    green;
    logic [ntg_pkg::BYTE_W-1:0]    red;
    logic [ntg_pkg::BYTE_W-1:0]    blue;

    modport source (output valid, output green, output red, output blue, input ready);
    modport sink (input valid, input green, input red, input blue, output ready);
endinterface

/* sv/ntg_cdiv.sv */
// Three-stage divider by a constant: reciprocal multiply, then one correction step
module ntg_cdiv #(
    parameter int NUM_W = 16,
    parameter int DIV   = 3,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] num,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [NUM_W-1:0] quo,
    output logic [NUM_W-1:0] rem,
    output logic [TAG_W-1:0] tag_out
);

    localparam int LO_W   = NUM_W / 2;
    localparam int HI_W   = NUM_W - LO_W;
    localparam int PROD_W = 2 * NUM_W + 2;
    localparam int DIV_W  = $clog2(DIV + 1);
    localparam int BACK_W = NUM_W + DIV_W;
    localparam longint unsigned RECIP = (64'd1 << NUM_W) / DIV;
    localparam logic [NUM_W:0]   RECIP_M = (NUM_W + 1)'(RECIP);
    localparam logic [NUM_W-1:0] DIV_N   = NUM_W'(DIV);
    localparam logic [DIV_W-1:0] DIV_K   = DIV_W'(DIV);

    logic [2:0]            vld_reg;
    logic [2:0]            en;
    logic [LO_W+NUM_W:0]   lo_prod_reg;
    logic [HI_W+NUM_W:0]   hi_prod_reg;
    logic [NUM_W-1:0]      num_a_reg;
    logic [TAG_W-1:0]      tag_a_reg;
    logic [NUM_W-1:0]      quo_b_reg;
    logic [NUM_W-1:0]      num_b_reg;
    logic [TAG_W-1:0]      tag_b_reg;
    logic [NUM_W-1:0]      quo_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [PROD_W-1:0]     full_prod;
    logic [NUM_W-1:0]      quo_b_next;
    logic [BACK_W-1:0]     back_prod;
    logic [NUM_W-1:0]      rem_raw;
    logic [NUM_W-1:0]      quo_next;
    logic [NUM_W-1:0]      rem_next;

    assign en[2]    = !vld_reg[2] || out_ready;
    assign en[1]    = !vld_reg[1] || en[2];
    assign en[0]    = !vld_reg[0] || en[1];
    assign in_ready = en[0];

    assign full_prod  = (PROD_W'(hi_prod_reg) << LO_W) + PROD_W'(lo_prod_reg);
    assign quo_b_next = full_prod[NUM_W +: NUM_W];

    assign back_prod = BACK_W'(quo_b_reg) * BACK_W'(DIV_K);
    assign rem_raw   = num_b_reg - back_prod[NUM_W-1:0];

    always_comb
    begin
        quo_next = quo_b_reg;
        rem_next = rem_raw;
        if (rem_raw >= DIV_N)
        begin
            quo_next = quo_b_reg + NUM_W'(1);
            rem_next = rem_raw - DIV_N;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (en[2])
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_prod_reg <= (LO_W + NUM_W + 1)'(num[LO_W-1:0]) * (LO_W + NUM_W + 1)'(RECIP_M);
            hi_prod_reg <= (HI_W + NUM_W + 1)'(num[NUM_W-1:LO_W])
                           * (HI_W + NUM_W + 1)'(RECIP_M);
            num_a_reg   <= num;
            tag_a_reg   <= tag_in;
        end
        if (en[1])
        begin
            quo_b_reg <= quo_b_next;
            num_b_reg <= num_a_reg;
            tag_b_reg <= tag_a_reg;
        end
        if (en[2])
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            tag_reg <= tag_b_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign tag_out   = tag_reg;

endmodule

/* sv/note_to_gamma_rgb_color_unit.sv */
// Top level of the note to gamma-corrected rainbow colour unit
//
//   channel  | direction | payload
//   ---------+-----------+---------------------------
//   notes    | in        | note[9:0], brightness[7:0]
//   colors   | out       | green, red, blue [7:0]
//   cfg      | in        | cfg_we, cfg_index, cfg_data
//
// One item per clock sustained while colors.ready stays high.
// Three constant dividers of three stages each, then seven stages for hue,
// sector ramp, saturation blend, brightness scale and gamma lookup.
// Reset clears all valid bits and loads root_offset 0, saturation 255.
// Each stage moves when its successor has room, so bubbles close up under a stall.
module note_to_gamma_rgb_color_unit #(
    parameter int NOTE_RANGE = 192
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ntg_note_if.sink                         notes,
    ntg_color_if.source                      colors,
    input  logic                             cfg_we,
    input  logic [ntg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ntg_pkg::BYTE_W-1:0]       cfg_data
);

    localparam int P_W     = 8 + $clog2(NOTE_RANGE + 1);
    localparam int OFF_MAX = (255 * NOTE_RANGE) / 120;
    localparam int SUM_W   = $clog2(1024 + OFF_MAX);
    localparam int POS_W   = $clog2(NOTE_RANGE);
    localparam int Y_W     = POS_W + 16;
    localparam int NST     = 7;

    logic [7:0]        root_offset_reg;
    logic [7:0]        saturation_reg;

    logic [P_W-1:0]    off_prod;
    logic              d1_valid, d1_ready;
    logic [P_W-1:0]    d1_quo, d1_rem;
    logic [17:0]       d1_tag;
    logic [SUM_W-1:0]  note_sum;
    logic              d2_valid, d2_ready;
    logic [SUM_W-1:0]  d2_quo, d2_rem;
    logic [7:0]        d2_tag;
    logic [POS_W-1:0]  pos;
    logic [Y_W-1:0]    scaled_pos;
    logic              d3_valid;
    logic [Y_W-1:0]    d3_quo, d3_rem;
    logic [7:0]        d3_tag;
    logic [15:0]       r_val;

    logic [NST-1:0]    vld_reg;
    logic [NST-1:0]    en;

    logic [1:0]        seg_next;
    logic [21:0]       t_next;
    logic [1:0]        seg_t_reg, seg_m_reg;
    logic [21:0]       t_reg;
    logic [45:0]       hprod_reg;
    logic [8:0]        hue_base;
    logic [7:0]        hue_next, hue_reg;
    logic [2:0]        sec_next, sec_reg;
    logic [5:0]        x_next;
    logic [28:0]       ramp_prod;
    logic [7:0]        ramp_reg;
    logic [7:0]        bri_t_reg, bri_m_reg, bri_h_reg, bri_r_reg, bri_b_reg;
    logic [7:0]        lvl_g, lvl_r, lvl_b;
    logic [8:0]        sat_eff;
    logic [15:0]       sat_bias;
    logic [15:0]       bl_g, bl_r, bl_b;
    logic [7:0]        bl_g_reg, bl_r_reg, bl_b_reg;
    logic [15:0]       sc_g, sc_r, sc_b;
    logic [7:0]        sc_g_reg, sc_r_reg, sc_b_reg;
    logic [7:0]        green_reg, red_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_offset_reg <= 8'd0;
            saturation_reg  <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ntg_pkg::REG_ROOT_OFFSET: root_offset_reg <= cfg_data;
                ntg_pkg::REG_SATURATION:  saturation_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign off_prod = P_W'(root_offset_reg) * P_W'(NOTE_RANGE);

    ntg_cdiv #(.NUM_W(P_W), .DIV(120), .TAG_W(18)) u_div_off (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (notes.valid),
        .in_ready  (notes.ready),
        .num       (off_prod),
        .tag_in    ({notes.note, notes.brightness}),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .quo       (d1_quo),
        .rem       (d1_rem),
        .tag_out   (d1_tag)
    );

    assign note_sum = SUM_W'(d1_tag[17:8]) + SUM_W'(d1_quo);

    ntg_cdiv #(.NUM_W(SUM_W), .DIV(NOTE_RANGE), .TAG_W(8)) u_div_range (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .num       (note_sum),
        .tag_in    (d1_tag[7:0]),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .quo       (d2_quo),
        .rem       (d2_rem),
        .tag_out   (d2_tag)
    );

    assign pos        = d2_rem[POS_W-1:0];
    assign scaled_pos = (Y_W'(pos) << 16) - Y_W'(pos);

    ntg_cdiv #(.NUM_W(Y_W), .DIV(NOTE_RANGE - 1), .TAG_W(8)) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .num       (scaled_pos),
        .tag_in    (d2_tag),
        .out_valid (d3_valid),
        .out_ready (en[0]),
        .quo       (d3_quo),
        .rem       (d3_rem),
        .tag_out   (d3_tag)
    );

    assign r_val = d3_quo[15:0];

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || colors.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= d3_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        if (r_val < ntg_pkg::SEG_MID_START)
        begin
            seg_next = ntg_pkg::SEG_LOW;
            t_next   = 22'(r_val) * 22'(ntg_pkg::SEG_LOW_SLOPE);
        end
        else if (r_val < ntg_pkg::SEG_TOP_START)
        begin
            seg_next = ntg_pkg::SEG_MID;
            t_next   = 22'(r_val - ntg_pkg::SEG_MID_START) * 22'(ntg_pkg::SEG_MID_SLOPE);
        end
        else
        begin
            seg_next = ntg_pkg::SEG_TOP;
            t_next   = 22'(r_val - ntg_pkg::SEG_TOP_START) * 22'(ntg_pkg::SEG_TOP_SLOPE);
        end
    end

    always_comb
    begin
        unique case (seg_m_reg)
            ntg_pkg::SEG_LOW: hue_base = ntg_pkg::SEG_LOW_BASE;
            ntg_pkg::SEG_MID: hue_base = ntg_pkg::SEG_MID_BASE;
            default:          hue_base = ntg_pkg::SEG_TOP_BASE;
        endcase
        hue_next = 8'(hue_base - 9'(hprod_reg[ntg_pkg::HUE_SHIFT +: 8]));
    end

    always_comb
    begin
        if (hue_reg < ntg_pkg::SEC_B1)
        begin
            sec_next = ntg_pkg::SEC_RG;
            x_next   = 6'(hue_reg);
        end
        else if (hue_reg < ntg_pkg::SEC_B2)
        begin
            sec_next = ntg_pkg::SEC_GR;
            x_next   = 6'(hue_reg - ntg_pkg::SEC_B1);
        end
        else if (hue_reg < ntg_pkg::SEC_B3)
        begin
            sec_next = ntg_pkg::SEC_GB;
            x_next   = 6'(hue_reg - ntg_pkg::SEC_B2);
        end
        else if (hue_reg < ntg_pkg::SEC_B4)
        begin
            sec_next = ntg_pkg::SEC_BG;
            x_next   = 6'(hue_reg - ntg_pkg::SEC_B3);
        end
        else if (hue_reg < ntg_pkg::SEC_B5)
        begin
            sec_next = ntg_pkg::SEC_BR;
            x_next   = 6'(hue_reg - ntg_pkg::SEC_B4);
        end
        else
        begin
            sec_next = ntg_pkg::SEC_RB;
            x_next   = 6'(hue_reg - ntg_pkg::SEC_B5);
        end
    end

    assign ramp_prod = 29'(x_next) * 29'(ntg_pkg::RAMP_M);

    always_comb
    begin
        lvl_g = 8'd0;
        lvl_r = 8'd0;
        lvl_b = 8'd0;
        unique case (sec_reg)
            ntg_pkg::SEC_RG:
            begin
                lvl_r = 8'd255;
                lvl_g = ramp_reg;
            end
            ntg_pkg::SEC_GR:
            begin
                lvl_g = 8'd255;
                lvl_r = 8'd255 - ramp_reg;
            end
            ntg_pkg::SEC_GB:
            begin
                lvl_g = 8'd255;
                lvl_b = ramp_reg;
            end
            ntg_pkg::SEC_BG:
            begin
                lvl_b = 8'd255;
                lvl_g = 8'd255 - ramp_reg;
            end
            ntg_pkg::SEC_BR:
            begin
                lvl_b = 8'd255;
                lvl_r = ramp_reg;
            end
            default:
            begin
                lvl_r = 8'd255;
                lvl_b = 8'd255 - ramp_reg;
            end
        endcase
    end

    assign sat_eff  = (saturation_reg > 8'd128) ? 9'(saturation_reg) + 9'd1
                                                : 9'(saturation_reg);
    assign sat_bias = 16'd255 * (16'd256 - 16'(sat_eff));
    assign bl_g     = 16'(lvl_g) * 16'(sat_eff) + sat_bias;
    assign bl_r     = 16'(lvl_r) * 16'(sat_eff) + sat_bias;
    assign bl_b     = 16'(lvl_b) * 16'(sat_eff) + sat_bias;

    assign sc_g = 16'(bl_g_reg) * 16'(bri_b_reg);
    assign sc_r = 16'(bl_r_reg) * 16'(bri_b_reg);
    assign sc_b = 16'(bl_b_reg) * 16'(bri_b_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            seg_t_reg <= seg_next;
            t_reg     <= t_next;
            bri_t_reg <= d3_tag;
        end
        if (en[1])
        begin
            seg_m_reg <= seg_t_reg;
            hprod_reg <= (seg_t_reg == ntg_pkg::SEG_TOP)
                         ? 46'(t_reg) * 46'(ntg_pkg::HUE_M_T)
                         : 46'(t_reg) * 46'(ntg_pkg::HUE_M_LM);
            bri_m_reg <= bri_t_reg;
        end
        if (en[2])
        begin
            hue_reg   <= hue_next;
            bri_h_reg <= bri_m_reg;
        end
        if (en[3])
        begin
            sec_reg   <= sec_next;
            ramp_reg  <= ramp_prod[ntg_pkg::RAMP_SHIFT +: 8];
            bri_r_reg <= bri_h_reg;
        end
        if (en[4])
        begin
            bl_g_reg  <= bl_g[15:8];
            bl_r_reg  <= bl_r[15:8];
            bl_b_reg  <= bl_b[15:8];
            bri_b_reg <= bri_r_reg;
        end
        if (en[5])
        begin
            sc_g_reg <= sc_g[15:8];
            sc_r_reg <= sc_r[15:8];
            sc_b_reg <= sc_b[15:8];
        end
        if (en[6])
        begin
            green_reg <= ntg_pkg::GAMMA_LUT[sc_g_reg];
            red_reg   <= ntg_pkg::GAMMA_LUT[sc_r_reg];
            blue_reg  <= ntg_pkg::GAMMA_LUT[sc_b_reg];
        end
    end

    assign colors.valid = vld_reg[NST-1];
    assign colors.green = green_reg;
    assign colors.red   = red_reg;
    assign colors.blue  = blue_reg;

endmodule

/* sv/ntg_checker.sv */
// Port-level checks of the colour unit and their binding
`include "note_to_gamma_rgb_color_unit_macros.svh"

module ntg_checker #(
    parameter int DEPTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] green,
    input logic [7:0] red,
    input logic [7:0] blue
);

    localparam int CNT_W = $clog2(DEPTH + 2);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            cnt_next = cnt_next + CNT_W'(1);
        end
        if (out_valid && out_ready)
        begin
            cnt_next = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `NTG_ASSERT_NOW(a_ready_when_drained, out_ready, in_ready, "input stalled while output drains")
    `NTG_ASSERT_NOW(a_no_phantom, cnt_reg == '0, !out_valid, "result with no item in flight")
    `NTG_ASSERT_NOW(a_depth, 1'b1, cnt_reg <= CNT_W'(DEPTH), "more items in flight than stages")
    `NTG_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable({green, red, blue}), "stalled item changed")

endmodule

bind note_to_gamma_rgb_color_unit ntg_checker u_ntg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (notes.valid),
    .in_ready  (notes.ready),
    .out_valid (colors.valid),
    .out_ready (colors.ready),
    .green     (colors.green),
    .red       (colors.red),
    .blue      (colors.blue)
);
